/* src/multilook_block_average_assert.svh */
// Assertion macros shared by the multilook block average RTL.
// Expects signals named clk and rst in the scope of each use.
`ifndef MULTILOOK_BLOCK_AVERAGE_ASSERT_SVH
`define MULTILOOK_BLOCK_AVERAGE_ASSERT_SVH

// same-cycle implication
`define MBA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mba_pkg.sv */
// Package for the multilook block average: item types, queue entry, back-end states.
// No dependencies.
package mba_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int DEF_MAX_COLUMNS = 4096;
  localparam int DEF_MAX_BANDS   = 8;
  localparam int DEF_MAX_FACTOR  = 16;
  localparam int IDX_LIMIT_W     = 20;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FACTOR  = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_ROWS    = 2'd2,
    CFG_BANDS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_valid;
  } px_item_t;

  typedef struct packed {
    logic signed [15:0] average;
    logic               has_data;
    logic [15:0]        out_row;
    logic [11:0]        out_column;
    logic [2:0]         band;
    logic               last;
  } res_item_t;

  typedef struct packed {
    logic [IDX_LIMIT_W-1:0]        idx;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_valid;
    logic                          emit;
    logic [15:0]                   out_row;
    logic [11:0]                   out_column;
    logic [2:0]                    band;
    logic                          last;
  } queue_entry_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

/* src/mba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/mba_fifo.sv */
// Short queue of classified items between the front and back ends.
// Depends on mba_pkg.
module mba_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  push,
  input  mba_pkg::queue_entry_t push_entry,
  input  logic                  pop,
  output mba_pkg::queue_entry_t head,
  output logic                  full,
  output logic                  empty
);
  import mba_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  queue_entry_t     entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/mba_divider.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// No dependencies.
module mba_divider #(
  parameter int SUM_W = 24,
  parameter int CNT_W = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    done,
  output logic [SUM_W-1:0]        quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  dsr;
  logic              neg;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [CNT_W:0]    rem_sh;
  logic              fits;

  assign rem_sh   = {rem, quo[SUM_W-1]};
  assign fits     = rem_sh >= {1'b0, dsr};
  assign quotient = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? CNT_W'(rem_sh - {1'b0, dsr}) : CNT_W'(rem_sh);
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/mba_front.sv */
// Front end: configuration registers, raster position tracking and item classification.
// Depends on mba_pkg.
module mba_front #(
  parameter int MAX_COLUMNS = mba_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_BANDS   = mba_pkg::DEF_MAX_BANDS,
  parameter int MAX_FACTOR  = mba_pkg::DEF_MAX_FACTOR
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               px_valid,
  output logic                               px_stall,
  input  mba_pkg::px_item_t                  px_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mba_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mba_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               cfg_write,
  input  logic                               clearing,
  input  logic                               q_full,
  output logic                               q_push,
  output mba_pkg::queue_entry_t              q_entry
);
  import mba_pkg::*;

  localparam int FACT_W = $clog2(MAX_FACTOR + 1);
  localparam int FMOD_W = $clog2(MAX_FACTOR);
  localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
  localparam int CPOS_W = $clog2(MAX_COLUMNS);
  localparam int BAND_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int BCNT_W = $clog2(MAX_BANDS + 1);
  localparam int IDX_W  = $clog2(MAX_COLUMNS * MAX_BANDS);
  localparam int CCMP_W = COL_W + 2;
  localparam int RCMP_W = 18;

  logic [4:0]  factor_reg;
  logic [12:0] columns_reg;
  logic [15:0] rows_reg;
  logic [3:0]  bands_reg;

  logic [FACT_W-1:0] f_eff;
  logic [COL_W-1:0]  cols_eff;
  logic [15:0]       rows_eff;
  logic [BCNT_W-1:0] bands_eff;

  logic [BAND_W-1:0] band_pos, band_pos_next;
  logic [CPOS_W-1:0] col_pos, col_pos_next;
  logic [FMOD_W-1:0] cmod, cmod_next;
  logic [CPOS_W-1:0] cbase, cbase_next;
  logic [CPOS_W-1:0] ocol, ocol_next;
  logic [15:0]       row_pos, row_pos_next;
  logic [FMOD_W-1:0] rmod, rmod_next;
  logic [15:0]       rbase, rbase_next;
  logic [15:0]       orow, orow_next;

  logic accept, band_last, col_last, row_last, cmod_last, rmod_last;
  logic whole_c, whole_r, last_c, last_r;
  logic [IDX_W-1:0] idx;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign px_stall  = q_full || clearing;
  assign accept    = px_valid && !px_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor_reg  <= 5'd1;
      columns_reg <= 13'd4096;
      rows_reg    <= 16'd65535;
      bands_reg   <= 4'd1;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FACTOR:  factor_reg  <= cfg_data[4:0];
        CFG_COLUMNS: columns_reg <= cfg_data[12:0];
        CFG_ROWS:    rows_reg    <= cfg_data[15:0];
        CFG_BANDS:   bands_reg   <= cfg_data[3:0];
        default:     factor_reg  <= factor_reg;
      endcase
    end
  end

  // out-of-range register values act as the nearest legal value
  always_comb begin
    if (factor_reg == '0) begin
      f_eff = FACT_W'(1);
    end else if (32'(factor_reg) > MAX_FACTOR) begin
      f_eff = FACT_W'(MAX_FACTOR);
    end else begin
      f_eff = FACT_W'(factor_reg);
    end
    if (columns_reg == '0) begin
      cols_eff = COL_W'(1);
    end else if (32'(columns_reg) > MAX_COLUMNS) begin
      cols_eff = COL_W'(MAX_COLUMNS);
    end else begin
      cols_eff = COL_W'(columns_reg);
    end
    rows_eff = (rows_reg == '0) ? 16'd1 : rows_reg;
    if (bands_reg == '0) begin
      bands_eff = BCNT_W'(1);
    end else if (32'(bands_reg) > MAX_BANDS) begin
      bands_eff = BCNT_W'(MAX_BANDS);
    end else begin
      bands_eff = BCNT_W'(bands_reg);
    end
  end

  assign band_last = band_pos == BAND_W'(bands_eff - BCNT_W'(1));
  assign col_last  = col_pos == CPOS_W'(cols_eff - COL_W'(1));
  assign row_last  = row_pos == rows_eff - 16'd1;
  assign cmod_last = cmod == FMOD_W'(f_eff - FACT_W'(1));
  assign rmod_last = rmod == FMOD_W'(f_eff - FACT_W'(1));

  // block is whole if it ends inside the image; last whole one if the next would not
  assign whole_c = (CCMP_W'(cbase) + CCMP_W'(f_eff)) <= CCMP_W'(cols_eff);
  assign last_c  = (CCMP_W'(cbase) + CCMP_W'(f_eff) + CCMP_W'(f_eff)) > CCMP_W'(cols_eff);
  assign whole_r = (RCMP_W'(rbase) + RCMP_W'(f_eff)) <= RCMP_W'(rows_eff);
  assign last_r  = (RCMP_W'(rbase) + RCMP_W'(f_eff) + RCMP_W'(f_eff)) > RCMP_W'(rows_eff);

  assign idx = IDX_W'(ocol) * IDX_W'(MAX_BANDS) + IDX_W'(band_pos);

  assign q_push = accept && whole_c && whole_r;

  always_comb begin
    q_entry              = '0;
    q_entry.idx          = IDX_LIMIT_W'(idx);
    q_entry.sample       = px_item.sample;
    q_entry.sample_valid = px_item.sample_valid;
    q_entry.emit         = cmod_last && rmod_last;
    q_entry.out_row      = orow;
    q_entry.out_column   = 12'(ocol);
    q_entry.band         = 3'(band_pos);
    q_entry.last         = last_r && last_c && band_last;
  end

  always_comb begin
    band_pos_next = band_pos;
    col_pos_next  = col_pos;
    cmod_next     = cmod;
    cbase_next    = cbase;
    ocol_next     = ocol;
    row_pos_next  = row_pos;
    rmod_next     = rmod;
    rbase_next    = rbase;
    orow_next     = orow;
    if (accept) begin
      if (!band_last) begin
        band_pos_next = band_pos + 1'b1;
      end else begin
        band_pos_next = '0;
        if (!col_last) begin
          col_pos_next = col_pos + 1'b1;
          if (cmod_last) begin
            cmod_next  = '0;
            cbase_next = cbase + CPOS_W'(f_eff);
            ocol_next  = ocol + 1'b1;
          end else begin
            cmod_next = cmod + 1'b1;
          end
        end else begin
          col_pos_next = '0;
          cmod_next    = '0;
          cbase_next   = '0;
          ocol_next    = '0;
          if (!row_last) begin
            row_pos_next = row_pos + 1'b1;
            if (rmod_last) begin
              rmod_next  = '0;
              rbase_next = rbase + 16'(f_eff);
              orow_next  = orow + 1'b1;
            end else begin
              rmod_next = rmod + 1'b1;
            end
          end else begin
            row_pos_next = '0;
            rmod_next    = '0;
            rbase_next   = '0;
            orow_next    = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      band_pos <= '0;
      col_pos  <= '0;
      cmod     <= '0;
      cbase    <= '0;
      ocol     <= '0;
      row_pos  <= '0;
      rmod     <= '0;
      rbase    <= '0;
      orow     <= '0;
    end else begin
      band_pos <= band_pos_next;
      col_pos  <= col_pos_next;
      cmod     <= cmod_next;
      cbase    <= cbase_next;
      ocol     <= ocol_next;
      row_pos  <= row_pos_next;
      rmod     <= rmod_next;
      rbase    <= rbase_next;
      orow     <= orow_next;
    end
  end

endmodule

/* src/mba_back.sv */
// Back end: sum/count store, read-modify-write, clearing pass, divide and result register.
// Depends on mba_pkg, mba_ram, mba_divider and the assertion macro header.
`include "multilook_block_average_assert.svh"

module mba_back #(
  parameter int MAX_COLUMNS = mba_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_BANDS   = mba_pkg::DEF_MAX_BANDS,
  parameter int MAX_FACTOR  = mba_pkg::DEF_MAX_FACTOR
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  output logic                  clearing,
  input  logic                  q_empty,
  input  mba_pkg::queue_entry_t q_head,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_stall,
  output mba_pkg::res_item_t    res_item
);
  import mba_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_BANDS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_FACTOR * MAX_FACTOR);
  localparam int ENT_W = SUM_W + CNT_W;

  back_state_t state, state_next;

  queue_entry_t       cur;
  logic [IDX_W-1:0]   clr_addr;
  logic               has_data;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic [ENT_W-1:0]   ram_rdata;
  logic signed [SUM_W-1:0] old_sum, new_sum;
  logic [CNT_W-1:0]   old_cnt, new_cnt;
  logic               div_start, div_done;
  logic [SUM_W-1:0]   div_q;
  logic               out_load;

  assign old_sum  = ram_rdata[ENT_W-1:CNT_W];
  assign old_cnt  = ram_rdata[CNT_W-1:0];
  assign new_sum  = cur.sample_valid
                  ? old_sum + {{(SUM_W-SAMPLE_BITS){cur.sample[SAMPLE_BITS-1]}}, cur.sample}
                  : old_sum;
  assign new_cnt  = cur.sample_valid ? old_cnt + 1'b1 : old_cnt;
  assign clearing = (state == BK_CLEAR);

  mba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (q_head.idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  mba_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (new_cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cur.idx[IDX_W-1:0];
    ram_wdata  = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        if (clr_addr == IDX_W'(DEPTH - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_READ;
        end
      end
      BK_READ: begin
        ram_we = 1'b1;
        if (cur.emit) begin
          div_start  = 1'b1;
          state_next = BK_DIV;
        end else begin
          ram_wdata  = {new_sum, new_cnt};
          state_next = BK_IDLE;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!res_valid || !res_stall) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_CLEAR;
    endcase
    if (cfg_write) begin
      state_next = BK_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      clr_addr <= '0;
    end else if (state == BK_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (div_start) begin
      has_data <= new_cnt != '0;
    end
    if (out_load) begin
      res_item.average    <= has_data ? 16'(div_q) : 16'sd0;
      res_item.has_data   <= has_data;
      res_item.out_row    <= cur.out_row;
      res_item.out_column <= cur.out_column;
      res_item.band       <= cur.band;
      res_item.last       <= cur.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  `MBA_ASSERT_IMPL(a_clear_no_pop, state == BK_CLEAR, !q_pop, "item popped during clearing pass")
  `MBA_ASSERT_NEXT(a_start_to_div, div_start && !cfg_write, state == BK_DIV, "divide not tracked")
  `MBA_ASSERT_IMPL(a_div_no_write, state == BK_DIV, !ram_we, "store written while dividing")

endmodule

/* src/multilook_block_average.sv */
// Top level of the multilook block average: block-averaging downsampler of a multiband raster.
// Depends on mba_pkg, mba_front, mba_fifo and mba_back.
//
// Usage: px_item carries one sample (band order within a pixel, pixels in raster order);
// it is taken at a clock edge with px_valid high and px_stall low. res_item carries one
// block average per band, taken with res_valid high and res_stall low. cfg_index/cfg_data
// write factor, image_columns, image_rows or band_count; cfg_ready is always high and any
// write restarts the image. Write configuration only while the block is idle.
// The front end takes one item per cycle into a 4-entry queue while px_stall is low. The back end does
// the sum/count store read-modify-write of each item in BK_IDLE and BK_READ; the last sample
// of a block goes on through BK_DIV for the bit-serial divide and BK_OUT.
// Samples outside whole blocks never enter the queue.
// After reset and after every configuration write the store is cleared one entry per
// cycle, all MAX_COLUMNS * MAX_BANDS entries (32768 at default size), with px_stall high.
// A stalled result sits in the output register while the back end keeps working on
// items that produce no result; a block end waits until the register is free.
module multilook_block_average #(
  parameter int MAX_COLUMNS = mba_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_BANDS   = mba_pkg::DEF_MAX_BANDS,
  parameter int MAX_FACTOR  = mba_pkg::DEF_MAX_FACTOR
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            px_valid,
  output logic                            px_stall,
  input  mba_pkg::px_item_t               px_item,
  output logic                            res_valid,
  input  logic                            res_stall,
  output mba_pkg::res_item_t              res_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mba_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mba_pkg::*;

  logic         cfg_write;
  logic         clearing;
  logic         q_full, q_empty, q_push, q_pop;
  queue_entry_t q_entry, q_head;

  mba_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_BANDS   (MAX_BANDS),
    .MAX_FACTOR  (MAX_FACTOR)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .px_valid  (px_valid),
    .px_stall  (px_stall),
    .px_item   (px_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_write (cfg_write),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  mba_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_write),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  mba_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_BANDS   (MAX_BANDS),
    .MAX_FACTOR  (MAX_FACTOR)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .clearing  (clearing),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule
